/* hw/rtl/atr_pkg.sv */
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types and constants for the average true range block.
// ----------------------------------------------------------------------------
package atr_pkg;

  localparam int PRICE_W      = 32;
  localparam int PERIOD_W     = 7;
  localparam int PERIOD_RESET = 14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MAX,
    S_SUM,
    S_START,
    S_DIV,
    S_OUT
  } atr_state_e;

endpackage

/* hw/rtl/average_true_range.sv */
// ----------------------------------------------------------------------------
// average_true_range
// Steps: the first bar of a series goes straight to S_OUT; any other bar passes
// S_DIFF, S_MAX and S_SUM, and for a valid average then S_START and S_DIV to S_OUT.
// A new bar is taken only in S_IDLE, once the last result is loaded into the output
// register; the bit-serial divider and a stalled sink both hold off the next bar.
// Reset: async, active low; period 14, no previous close, empty window.
// ----------------------------------------------------------------------------
module average_true_range #(
  parameter int MAX_PERIOD = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: averaging_period
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atr_pkg::PERIOD_W-1:0]  cfg_data_i,
  // bars in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [3*atr_pkg::PRICE_W-1:0] s_axis_tdata,  // bar_high, bar_low, bar_close
  input  logic                          s_axis_tuser,  // new_series
  // averages out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [atr_pkg::PRICE_W-1:0]   m_axis_tdata,  // range_average
  output logic                          m_axis_tuser   // average_valid
);
  import atr_pkg::*;

  localparam int IW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int PW = $clog2(MAX_PERIOD + 1);
  localparam int SW = PRICE_W + PW;

  atr_state_e state_q, state_d;

  logic [PERIOD_W-1:0] period_q;
  logic [PW-1:0]       p_eff;
  logic [PRICE_W-1:0]  high_q, low_q, close_q, prev_close_q;
  logic                have_prev_q;
  logic [PRICE_W-1:0]  hl_q, dh_q, dl_q, tr_q, rd_q;
  logic [IW-1:0]       wr_idx_q;
  logic [PW-1:0]       seen_q;
  logic [SW-1:0]       sum_q;
  logic                evict_q;
  logic [PRICE_W-1:0]  res_avg_q;
  logic                res_ok_q;
  logic                m_valid_q;
  logic [PRICE_W-1:0]  m_data_q;
  logic                m_user_q;

  logic [PRICE_W-1:0]  ring_mem [MAX_PERIOD];

  logic                in_acc, cfg_acc, first_bar, out_load, avg_ok;
  logic [PW-1:0]       w_ext, old_ext;
  logic [IW-1:0]       old_idx;
  logic [PRICE_W-1:0]  tr_a;
  logic                div_start;
  logic                div_done;
  logic [PRICE_W-1:0]  quotient;

  // effective period: zero acts as one, clamp to the ring depth
  always_comb begin
    if (period_q == '0) begin
      p_eff = PW'(1);
    end else if (int'(period_q) > MAX_PERIOD) begin
      p_eff = PW'(MAX_PERIOD);
    end else begin
      p_eff = PW'(period_q);
    end
  end

  always_comb begin
    w_ext = PW'(wr_idx_q);
    if (w_ext >= p_eff) begin
      old_ext = w_ext - p_eff;
    end else begin
      old_ext = w_ext + PW'(MAX_PERIOD) - p_eff;
    end
    old_idx = old_ext[IW-1:0];
  end

  assign tr_a      = (dh_q > hl_q) ? dh_q : hl_q;
  assign first_bar = s_axis_tuser || !have_prev_q;
  assign avg_ok    = evict_q || ((seen_q + PW'(1)) >= p_eff);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = first_bar ? S_OUT : S_DIFF;
      S_DIFF:  state_d = S_MAX;
      S_MAX:   state_d = S_SUM;
      S_SUM:   state_d = avg_ok ? S_START : S_OUT;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cfg_ready_o   = 1'b1;
      end
      S_START: div_start = 1'b1;
      S_OUT:   out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  atr_div #(
    .DIVIDEND_W (SW),
    .DIVISOR_W  (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (p_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      period_q     <= PERIOD_W'(PERIOD_RESET);
      have_prev_q  <= 1'b0;
      prev_close_q <= '0;
      wr_idx_q     <= '0;
      seen_q       <= '0;
      sum_q        <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_acc) period_q <= cfg_data_i;

      if (cfg_acc || (in_acc && first_bar)) begin
        wr_idx_q <= '0;
        seen_q   <= '0;
        sum_q    <= '0;
      end

      if (in_acc && first_bar) begin
        have_prev_q  <= 1'b1;
        prev_close_q <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
      end

      unique case (state_q)
        S_DIFF: prev_close_q <= close_q;
        S_MAX:  if (evict_q) sum_q <= sum_q - SW'(rd_q);
        S_SUM: begin
          sum_q    <= sum_q + SW'(tr_q);
          wr_idx_q <= (wr_idx_q == IW'(MAX_PERIOD - 1)) ? '0 : wr_idx_q + IW'(1);
          if (!evict_q) seen_q <= seen_q + PW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      high_q    <= s_axis_tdata[PRICE_W-1:0];
      low_q     <= s_axis_tdata[2*PRICE_W-1:PRICE_W];
      close_q   <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
      res_avg_q <= '0;
      res_ok_q  <= 1'b0;
    end
    if (state_q == S_DIFF) begin
      hl_q    <= (high_q >= low_q) ? high_q - low_q : '0;
      dh_q    <= (high_q >= prev_close_q) ? high_q - prev_close_q : prev_close_q - high_q;
      dl_q    <= (low_q >= prev_close_q) ? low_q - prev_close_q : prev_close_q - low_q;
      evict_q <= (seen_q >= p_eff);
    end
    if (state_q == S_MAX) begin
      tr_q <= (dl_q > tr_a) ? dl_q : tr_a;
    end
    if (state_q == S_DIV && div_done) begin
      res_avg_q <= quotient;
      res_ok_q  <= 1'b1;
    end
    if (out_load) begin
      m_data_q <= res_avg_q;
      m_user_q <= res_ok_q;
    end
  end

  // true-range ring: oldest entry read in S_DIFF, newest written in S_SUM
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIFF) begin
      rd_q <= ring_mem[old_idx];
    end
    if (state_q == S_SUM) begin
      ring_mem[wr_idx_q] <= tr_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* hw/rtl/atr_div.sv */
// ----------------------------------------------------------------------------
// atr_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module atr_div #(
  parameter int DIVIDEND_W = 39,
  parameter int DIVISOR_W  = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_W-1:0]    dividend_i,
  input  logic [DIVISOR_W-1:0]     divisor_i,
  output logic                     done_o,
  output logic [atr_pkg::PRICE_W-1:0] quotient_o
);
  import atr_pkg::*;

  localparam int CW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         count_q;
  logic [DIVIDEND_W-1:0] dvd_q;      // dividend bits out the top, quotient bits in the bottom
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;

  always_comb begin
    trial = {rem_q, dvd_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = (trial >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        count_q <= '0;
      end else if (busy_q) begin
        if (count_q == CW'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dvd_q <= {dvd_q[DIVIDEND_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[PRICE_W-1:0];

endmodule
